### rtl/rmi_pkg.sv
// Shared types, constants and helpers for the range-max counter array.
`default_nettype none
package rmi_pkg;

  localparam int ENTRIES     = 256;
  localparam int VALUE_BITS  = 31;
  localparam int IDX_W       = (ENTRIES > 2) ? $clog2(ENTRIES) : 1;
  localparam int RANGE_W     = 8;
  localparam int CMP_W       = (IDX_W > RANGE_W) ? IDX_W : RANGE_W;
  localparam int FIELD_W     = 31;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [RANGE_W-1:0]    range_t;
  typedef logic [FIELD_W-1:0]    field_t;

  localparam value_t VALUE_MAX = '1;
  localparam idx_t   LAST_IDX  = idx_t'(ENTRIES - 1);

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_INCR  = 2'd2,
    KIND_RESET = 2'd3
  } kind_e;

  typedef struct packed {
    logic   shift;
    value_t tail;
  } chain_t;

  function automatic value_t fit_value(field_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[VALUE_BITS-1:0];
  endfunction

  function automatic field_t to_field(value_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[FIELD_W-1:0];
  endfunction

endpackage
`default_nettype wire

### rtl/rmi_in_if.sv
// Input channel: item kind, range bounds and load value.
`default_nettype none
interface rmi_in_if import rmi_pkg::*; ();
  logic   valid;
  logic   ready;
  kind_e  kind;
  range_t range_low;
  range_t range_high;
  field_t load_value;

  modport source (output valid, kind, range_low, range_high, load_value, input ready);
  modport sink   (input valid, kind, range_low, range_high, load_value, output ready);
endinterface
`default_nettype wire

### rtl/rmi_out_if.sv
// Output channel: one result value per item.
`default_nettype none
interface rmi_out_if import rmi_pkg::*; ();
  logic   valid;
  logic   ready;
  field_t result_value;

  modport source (output valid, result_value, input ready);
  modport sink   (input valid, result_value, output ready);
endinterface
`default_nettype wire

### rtl/rmi_cell.sv
// One storage cell of the rotating entry chain.
`default_nettype none
module rmi_cell import rmi_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         shift_i,
  input  wire value_t d_i,
  output value_t      q_o
);

  value_t val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else if (shift_i) begin
      val_q <= d_i;
    end
  end

  assign q_o = val_q;

endmodule
`default_nettype wire

### rtl/rmi_ctrl.sv
// Sequencer and head processing stage: applies each item to entries as they pass.
`default_nettype none
module rmi_ctrl import rmi_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  rmi_in_if.sink      in_if,
  rmi_out_if.source   out_if,
  input  wire value_t head_i,
  output chain_t      chain_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WALK
  } state_e;

  state_e state_q;
  idx_t   cnt_q;
  value_t best_q;
  value_t top_q;
  kind_e  kind_q;
  range_t lo_q;
  range_t hi_q;
  value_t val_q;
  logic   out_valid_q;
  field_t out_data_q;

  logic       last;
  logic       out_busy;
  logic       walk_go;
  logic       in_rng;
  logic [CMP_W-1:0] idx_ext;
  logic [CMP_W-1:0] lo_ext;
  logic [CMP_W-1:0] hi_ext;
  value_t     best_nxt;
  value_t     tail;

  assign last     = (cnt_q == LAST_IDX);
  assign out_busy = out_valid_q && !out_if.ready;
  assign walk_go  = !(last && out_busy);
  assign idx_ext  = CMP_W'(cnt_q);
  assign lo_ext   = CMP_W'(lo_q);
  assign hi_ext   = CMP_W'(hi_q);
  assign in_rng   = (lo_q <= hi_q) && (idx_ext >= lo_ext) && (idx_ext <= hi_ext);

  always_comb begin
    best_nxt = best_q;
    tail     = head_i;
    if (state_q == S_SCAN) begin
      if (head_i > best_q) best_nxt = head_i;
    end else begin
      case (kind_q)
        KIND_LOAD: begin
          if (idx_ext == lo_ext) tail = val_q;
        end
        KIND_QUERY: begin
          if (in_rng && (head_i > best_q)) best_nxt = head_i;
        end
        KIND_INCR: begin
          if (in_rng && (head_i != VALUE_MAX)) tail = head_i + value_t'(1);
        end
        KIND_RESET: begin
          if (in_rng && (head_i == top_q)) tail = '0;
        end
        default: begin
          tail = head_i;
        end
      endcase
    end
  end

  assign chain_o.shift = (state_q == S_SCAN) || ((state_q == S_WALK) && walk_go);
  assign chain_o.tail  = tail;

  assign in_if.ready         = (state_q == S_IDLE);
  assign out_if.valid        = out_valid_q;
  assign out_if.result_value = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      best_q      <= '0;
      top_q       <= '0;
      kind_q      <= KIND_LOAD;
      lo_q        <= '0;
      hi_q        <= '0;
      val_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if ((state_q == S_WALK) && walk_go && last) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_if.valid) begin
            kind_q  <= in_if.kind;
            lo_q    <= in_if.range_low;
            hi_q    <= in_if.range_high;
            val_q   <= fit_value(in_if.load_value);
            cnt_q   <= '0;
            best_q  <= '0;
            state_q <= (in_if.kind == KIND_RESET) ? S_SCAN : S_WALK;
          end
        end
        S_SCAN: begin
          if (last) begin
            cnt_q   <= '0;
            top_q   <= best_nxt;
            best_q  <= '0;
            state_q <= S_WALK;
          end else begin
            cnt_q  <= cnt_q + idx_t'(1);
            best_q <= best_nxt;
          end
        end
        S_WALK: begin
          if (walk_go) begin
            best_q <= best_nxt;
            if (last) begin
              cnt_q       <= '0;
              out_data_q  <= (kind_q == KIND_QUERY) ? to_field(best_nxt) : '0;
              state_q     <= S_IDLE;
            end else begin
              cnt_q <= cnt_q + idx_t'(1);
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/range_max_increment_reset_array.sv
// Range-max / range-increment / reset-max counter array, top level.
//
// Input channel in_if carries one item per transaction: kind, range_low,
// range_high and load_value. Output channel out_if returns one result_value
// per item, in item order: the range maximum for a query, zero otherwise.
// Entries live in a ring of cells that rotates by one place per cycle while
// an item is in progress, unless a stalled output holds it; a single head
// stage sees each entry as it passes and loads, increments, clears or folds
// it into the running maximum. The result is ready after one full rotation
// of the ring; a reset-max needs an extra rotation to find the global
// maximum first. One item is in progress at a time, and the next can be
// accepted in the cycle after the ring finishes.
// Reset clears every entry to zero and empties the output register.
// A finished result is held in the output register; the next item is
// accepted while it waits. If the receiver still stalls when the following
// item completes, the ring holds on its last step until the result is taken.
`default_nettype none
module range_max_increment_reset_array import rmi_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  rmi_in_if.sink     in_if,
  rmi_out_if.source  out_if
);

  chain_t chain;
  value_t cell_q [ENTRIES];

  rmi_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .out_if  (out_if),
    .head_i  (cell_q[0]),
    .chain_o (chain)
  );

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == ENTRIES - 1) begin : g_tail
      rmi_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (chain.shift),
        .d_i     (chain.tail),
        .q_o     (cell_q[i])
      );
    end else begin : g_mid
      rmi_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (chain.shift),
        .d_i     (cell_q[i+1]),
        .q_o     (cell_q[i])
      );
    end
  end

endmodule
`default_nettype wire

### verif/tb.sv
// Testbench for the range-max / range-increment / reset-max counter array.
`default_nettype none
module tb import rmi_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    kind_e  kind;
    range_t lo;
    range_t hi;
    field_t val;
    bit     hold;
  } item_t;

  logic clk_i;
  logic rst_ni;

  rmi_in_if  in_if ();
  rmi_out_if out_if ();

  range_max_increment_reset_array u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  value_t counts [ENTRIES] = '{default: '0};
  item_t  items_q[$];
  field_t range_max_q[$];
  int     n_items;
  int     sent;
  int     done;
  int     errors;

  function automatic field_t update_counts(kind_e k, range_t lo, range_t hi, field_t v);
    value_t best;
    value_t top;
    int     first;
    int     last;
    best = '0;
    top  = '0;
    if (k == KIND_LOAD) begin
      if (int'(lo) < ENTRIES) counts[int'(lo)] = value_t'(v);
    end else if (lo <= hi && int'(lo) < ENTRIES) begin
      first = int'(lo);
      last  = (int'(hi) >= ENTRIES) ? ENTRIES - 1 : int'(hi);
      case (k)
        KIND_QUERY: begin
          for (int i = first; i <= last; i++)
            if (counts[i] > best) best = counts[i];
        end
        KIND_INCR: begin
          for (int i = first; i <= last; i++)
            if (counts[i] != VALUE_MAX) counts[i] = counts[i] + 1'b1;
        end
        default: begin
          for (int i = 0; i < ENTRIES; i++)
            if (counts[i] > top) top = counts[i];
          for (int i = first; i <= last; i++)
            if (counts[i] == top) counts[i] = '0;
        end
      endcase
    end
    return field_t'(best);
  endfunction

  function automatic void add_item(kind_e k, int lo, int hi, field_t v, bit hold);
    item_t it;
    it.kind = k;
    it.lo   = range_t'(lo);
    it.hi   = range_t'(hi);
    it.val  = v;
    it.hold = hold;
    items_q = {items_q, it};
  endfunction

  function automatic field_t pick_value();
    case ($urandom_range(0, 3))
      0:       return field_t'($urandom_range(0, 15));
      1:       return field_t'(VALUE_MAX) - field_t'($urandom_range(0, 2));
      2:       return field_t'($urandom());
      default: return field_t'($urandom_range(1000, 1100));
    endcase
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #30_000_000;
    $display("simulation failed");
    $finish;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    item_t  it;
    field_t exp_v;
    if (!rst_ni) begin
      in_if.valid      <= 1'b0;
      in_if.kind       <= KIND_LOAD;
      in_if.range_low  <= '0;
      in_if.range_high <= '0;
      in_if.load_value <= '0;
      sent             <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        exp_v = update_counts(in_if.kind, in_if.range_low, in_if.range_high,
                              in_if.load_value);
        range_max_q = {range_max_q, exp_v};
        sent <= sent + 1;
      end
      if (!in_if.valid || in_if.ready) begin
        if (items_q.size() > 0 && !(items_q[0].hold && (in_if.valid || sent != done)) &&
            ((sent >= 400 && sent < 700) || $urandom_range(0, 99) >= 7)) begin
          it = items_q.pop_front();
          in_if.valid      <= 1'b1;
          in_if.kind       <= it.kind;
          in_if.range_low  <= it.lo;
          in_if.range_high <= it.hi;
          in_if.load_value <= it.val;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    field_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      done         <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (range_max_q.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual %0d", $time,
                   out_if.result_value);
          errors++;
        end else begin
          want = range_max_q.pop_front();
          if (out_if.result_value !== want) begin
            $display("%0t: result_value mismatch, expected %0d, actual %0d", $time, want,
                     out_if.result_value);
            errors++;
          end
        end
        done <= done + 1;
      end
      out_if.ready <= (done >= 400 && done < 700) || $urandom_range(0, 99) >= 7;
    end
  end

  initial begin
    kind_e k;
    int    roll;
    int    lo;
    int    hi;
    rst_ni           = 1'b0;

    add_item(KIND_QUERY, 0, 255, field_t'($urandom()), 1'b0);
    add_item(KIND_RESET, 0, 255, field_t'($urandom()), 1'b0);
    add_item(KIND_LOAD, 0, $urandom_range(0, 255), field_t'(VALUE_MAX), 1'b0);
    add_item(KIND_LOAD, 255, 0, field_t'(VALUE_MAX) - 1'b1, 1'b0);
    add_item(KIND_INCR, 0, 255, field_t'($urandom()), 1'b0);
    add_item(KIND_QUERY, 0, 255, field_t'($urandom()), 1'b0);
    add_item(KIND_QUERY, 255, 255, field_t'($urandom()), 1'b0);
    add_item(KIND_QUERY, 1, 254, field_t'($urandom()), 1'b0);
    add_item(KIND_QUERY, 10, 9, field_t'($urandom()), 1'b0);
    add_item(KIND_INCR, 200, 100, field_t'($urandom()), 1'b0);
    add_item(KIND_RESET, 255, 0, field_t'($urandom()), 1'b0);
    add_item(KIND_RESET, 0, 0, field_t'($urandom()), 1'b0);
    add_item(KIND_QUERY, 0, 255, field_t'($urandom()), 1'b0);
    add_item(KIND_RESET, 0, 255, field_t'($urandom()), 1'b0);
    add_item(KIND_QUERY, 0, 255, field_t'($urandom()), 1'b0);
    add_item(KIND_LOAD, 128, 255, 31'h5555_5555, 1'b0);
    add_item(KIND_LOAD, 127, 0, 31'h2AAA_AAAA, 1'b0);
    add_item(KIND_QUERY, 127, 128, field_t'($urandom()), 1'b0);
    add_item(KIND_INCR, 127, 127, field_t'($urandom()), 1'b0);
    add_item(KIND_QUERY, 126, 127, field_t'($urandom()), 1'b0);
    add_item(KIND_RESET, 100, 200, field_t'($urandom()), 1'b0);
    add_item(KIND_QUERY, 0, 255, field_t'($urandom()), 1'b0);

    for (int n = 0; n < 1150; n++) begin
      roll = $urandom_range(0, 99);
      k = (roll < 30) ? KIND_LOAD : (roll < 60) ? KIND_QUERY :
          (roll < 82) ? KIND_INCR : KIND_RESET;
      roll = $urandom_range(0, 99);
      if (k == KIND_RESET && roll < 50) begin
        lo = $urandom_range(0, 3);
        hi = $urandom_range(252, 255);
      end else if (roll < 10) begin
        lo = $urandom_range(1, 255);
        hi = $urandom_range(0, lo - 1);
      end else if (roll < 50) begin
        lo = $urandom_range(0, 255);
        hi = lo + $urandom_range(0, 7);
        if (hi > 255) hi = 255;
      end else if (roll < 80) begin
        lo = $urandom_range(0, 255);
        hi = $urandom_range(lo, 255);
      end else begin
        lo = $urandom_range(0, 1) ? 0 : $urandom_range(0, 255);
        hi = $urandom_range(0, 1) ? 255 : $urandom_range(lo, 255);
      end
      if (k == KIND_LOAD) hi = $urandom_range(0, 255);
      add_item(k, lo, hi, (k == KIND_LOAD) ? pick_value() : field_t'($urandom()),
               n == 0 || n == 575);
    end
    n_items = items_q.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (done == n_items);
    repeat (2 * ENTRIES + 16) @(posedge clk_i);
    if (errors == 0 && range_max_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
